// ===== hw/rtl/bpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpwd_pkg: shared types and constants
// Holds the band count, the fixed widths, the config register indexes, the
// back-end state type and the 2^(-2^(k-16)) coefficient table.
// ----------------------------------------------------------------------------
package bpwd_pkg;

    localparam int NBANDS    = 8;
    localparam int STR_W     = 32;
    localparam int SUM_W     = 32;
    localparam int PH_W      = 48;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = SUM_W + 1;
    localparam int LOG_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DETAIL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMARY = 2'd1;

    localparam logic [STR_W-1:0] DETAIL_STRIDE_RST  = 32'd6553600;
    localparam logic [STR_W-1:0] SUMMARY_STRIDE_RST = 32'd655360000;
    localparam logic [STR_W-1:0] FRAME_STEP         = 32'h0001_0000;

    // 0.632 in Q16
    localparam logic [16:0] GAMMA_Q16 = 17'd41419;

    typedef struct packed {
        logic kind;   // 0 detail, 1 summary
        logic last;   // final point of its frame
        logic avg;    // values are sums to divide by the count
    } t_job_ctl;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_BAND,
        BK_DIV,
        BK_CLASS,
        BK_LOG,
        BK_GAM,
        BK_EXP,
        BK_FIN,
        BK_OUT
    } t_bk_state;

    function automatic logic [63:0] pw_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Coefficient used for fraction bit k of the exponent, Q30.
    function automatic logic [30:0] pw_coef(input int k);
        logic [63:0] c;
        c = pw_isqrt(64'd1 << 59);
        for (int i = 0; i < 15; i++) begin
            if (i < 15 - k) begin
                c = pw_isqrt(c << 30);
            end
        end
        return c[30:0];
    endfunction

    localparam logic [30:0] PW_COEF [16] = '{
        pw_coef(0),  pw_coef(1),  pw_coef(2),  pw_coef(3),
        pw_coef(4),  pw_coef(5),  pw_coef(6),  pw_coef(7),
        pw_coef(8),  pw_coef(9),  pw_coef(10), pw_coef(11),
        pw_coef(12), pw_coef(13), pw_coef(14), pw_coef(15)
    };

endpackage

// ===== hw/rtl/band_peak_waveform_decimator.sv =====
// ----------------------------------------------------------------------------
// band_peak_waveform_decimator: peak-hold waveform point generator
// Tracks per-band peaks of stereo frames and emits detail and summary points.
// ----------------------------------------------------------------------------
// A frame word is taken whenever the two-entry job queue has room for the
// points that frame will cause; frames that land on no boundary are never
// held up. Each detail or summary point is built by the level engine one
// band at a time: a summary band with a nonzero count first runs a 33-step
// restoring divide for its average, and a power-curve band then runs 16
// squaring steps for log2, one gamma multiply and 16 exponent multiply
// steps, while a linear band or a zero/full-scale value skips the power
// curve. The intake stalls only when the queue lacks room for the frame's
// points. The finished point sits in an output register so the engine can
// start the next job while the sink stalls. Strides are written on the
// config port (index 0 detail, index 1 summary, other indexes ignored); the
// port is always ready.
// ----------------------------------------------------------------------------
module band_peak_waveform_decimator #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bpwd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bpwd_pkg::STR_W-1:0]           i_cfg_data,
    // frame input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_full_left,
    input  logic signed [SAMPLE_BITS-1:0]        i_full_right,
    input  logic signed [SAMPLE_BITS-1:0]        i_low_left,
    input  logic signed [SAMPLE_BITS-1:0]        i_low_right,
    input  logic signed [SAMPLE_BITS-1:0]        i_mid_left,
    input  logic signed [SAMPLE_BITS-1:0]        i_mid_right,
    input  logic signed [SAMPLE_BITS-1:0]        i_high_left,
    input  logic signed [SAMPLE_BITS-1:0]        i_high_right,
    // point output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_point_kind,
    output logic [7:0]                           o_all_left_level,
    output logic [7:0]                           o_low_left_level,
    output logic [7:0]                           o_mid_left_level,
    output logic [7:0]                           o_high_left_level,
    output logic [7:0]                           o_all_right_level,
    output logic [7:0]                           o_low_right_level,
    output logic [7:0]                           o_mid_right_level,
    output logic [7:0]                           o_high_right_level,
    output logic                                 o_last_of_frame
);
    import bpwd_pkg::*;

    logic [NBANDS-1:0][SAMPLE_BITS-1:0] sample;
    logic [1:0]                         push_n, free;
    t_job_ctl                           ctl_a, ctl_b, q_ctl;
    logic [NBANDS-1:0][SUM_W-1:0]       val_a, val_b, q_val;
    logic [COUNT_BITS-1:0]              cnt_a, cnt_b, q_cnt;
    logic                               q_empty, q_pop;
    logic [NBANDS-1:0][7:0]             level;

    assign o_cfg_ready = 1'b1;

    // band order: full, low, mid, high, left before right
    assign sample[0] = i_full_left;
    assign sample[1] = i_full_right;
    assign sample[2] = i_low_left;
    assign sample[3] = i_low_right;
    assign sample[4] = i_mid_left;
    assign sample[5] = i_mid_right;
    assign sample[6] = i_high_left;
    assign sample[7] = i_high_right;

    bpwd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_sample    (sample),
        .i_free      (free),
        .o_push_n    (push_n),
        .o_ctl_a     (ctl_a),
        .o_ctl_b     (ctl_b),
        .o_val_a     (val_a),
        .o_val_b     (val_b),
        .o_cnt_a     (cnt_a),
        .o_cnt_b     (cnt_b)
    );

    bpwd_queue #(
        .COUNT_BITS (COUNT_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_ctl_a  (ctl_a),
        .i_ctl_b  (ctl_b),
        .i_val_a  (val_a),
        .i_val_b  (val_b),
        .i_cnt_a  (cnt_a),
        .i_cnt_b  (cnt_b),
        .o_free   (free),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_ctl    (q_ctl),
        .o_val    (q_val),
        .o_cnt    (q_cnt)
    );

    bpwd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_ctl   (q_ctl),
        .i_val   (q_val),
        .i_cnt   (q_cnt),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_kind  (o_point_kind),
        .o_last  (o_last_of_frame),
        .o_level (level)
    );

    assign o_all_left_level   = level[0];
    assign o_all_right_level  = level[1];
    assign o_low_left_level   = level[2];
    assign o_low_right_level  = level[3];
    assign o_mid_left_level   = level[4];
    assign o_mid_right_level  = level[5];
    assign o_high_left_level  = level[6];
    assign o_high_right_level = level[7];

endmodule

// ===== hw/rtl/bpwd_front.sv =====
// ----------------------------------------------------------------------------
// bpwd_front: frame intake
// Holds peaks, summary sums, count, phases and strides; on each frame
// decides the boundaries and pushes point jobs to the queue.
// ----------------------------------------------------------------------------
module bpwd_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [bpwd_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [bpwd_pkg::STR_W-1:0]                  i_cfg_data,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic [bpwd_pkg::NBANDS-1:0][SAMPLE_BITS-1:0] i_sample,
    input  logic [1:0]                                  i_free,
    output logic [1:0]                                  o_push_n,
    output bpwd_pkg::t_job_ctl                          o_ctl_a,
    output bpwd_pkg::t_job_ctl                          o_ctl_b,
    output logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] o_val_a,
    output logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] o_val_b,
    output logic [COUNT_BITS-1:0]                       o_cnt_a,
    output logic [COUNT_BITS-1:0]                       o_cnt_b
);
    import bpwd_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [STR_W-1:0]       r_dstr, r_sstr;
    logic [SAMPLE_BITS-1:0] r_peak [NBANDS];
    logic [SUM_W-1:0]       r_sum  [NBANDS];
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [PH_W-1:0]        r_dph, r_sph;

    logic [STR_W-1:0]       ds, ss;
    logic [PH_W-1:0]        dnext, snext;
    logic                   fire_d, fire_s, add_ok, accept;
    logic [1:0]             need;
    logic [SAMPLE_BITS-1:0] mag    [NBANDS];
    logic [SAMPLE_BITS-1:0] pk_new [NBANDS];
    logic [SUM_W-1:0]       sum_new[NBANDS];
    logic [COUNT_BITS-1:0]  cnt_new;
    t_job_ctl               ctl_d, ctl_s;
    logic [NBANDS-1:0][SUM_W-1:0] val_d, val_s;

    always_comb begin
        ds     = (r_dstr < FRAME_STEP) ? FRAME_STEP : r_dstr;
        ss     = (r_sstr < FRAME_STEP) ? FRAME_STEP : r_sstr;
        dnext  = r_dph + PH_W'(FRAME_STEP);
        snext  = r_sph + PH_W'(FRAME_STEP);
        fire_d = dnext >= PH_W'(ds);
        fire_s = snext >= PH_W'(ss);
        need   = {1'b0, fire_d} + {1'b0, fire_s};
        o_stall = need > i_free;
        accept = i_valid && !o_stall;
        add_ok = fire_d && (r_cnt != CNT_MAX);
        cnt_new = add_ok ? r_cnt + 1'b1 : r_cnt;
        for (int i = 0; i < NBANDS; i++) begin
            mag[i] = i_sample[i][SAMPLE_BITS-1] ? (~i_sample[i] + 1'b1) : i_sample[i];
            pk_new[i] = (mag[i] > r_peak[i]) ? mag[i] : r_peak[i];
            sum_new[i] = add_ok ? r_sum[i] + SUM_W'(pk_new[i]) : r_sum[i];
            val_d[i] = SUM_W'(pk_new[i]);
            val_s[i] = (cnt_new != '0) ? sum_new[i] : SUM_W'(pk_new[i]);
        end
        ctl_d = '{kind: 1'b0, last: !fire_s, avg: 1'b0};
        ctl_s = '{kind: 1'b1, last: 1'b1, avg: (cnt_new != '0)};
        o_ctl_a  = fire_d ? ctl_d : ctl_s;
        o_val_a  = fire_d ? val_d : val_s;
        o_cnt_a  = cnt_new;
        o_ctl_b  = ctl_s;
        o_val_b  = val_s;
        o_cnt_b  = cnt_new;
        o_push_n = accept ? need : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstr <= DETAIL_STRIDE_RST;
            r_sstr <= SUMMARY_STRIDE_RST;
            r_cnt  <= '0;
            r_dph  <= '0;
            r_sph  <= '0;
            for (int i = 0; i < NBANDS; i++) begin
                r_peak[i] <= '0;
                r_sum[i]  <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_DETAIL) begin
                r_dstr <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_SUMMARY) begin
                r_sstr <= i_cfg_data;
            end
            if (accept) begin
                r_dph <= fire_d ? dnext - PH_W'(ds) : dnext;
                r_sph <= fire_s ? snext - PH_W'(ss) : snext;
                r_cnt <= fire_s ? '0 : cnt_new;
                for (int i = 0; i < NBANDS; i++) begin
                    r_peak[i] <= fire_d ? '0 : pk_new[i];
                    r_sum[i]  <= fire_s ? '0 : sum_new[i];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/bpwd_queue.sv =====
// ----------------------------------------------------------------------------
// bpwd_queue: two-entry job queue
// Takes up to two jobs a cycle from the front, one a cycle to the back on pop.
// ----------------------------------------------------------------------------
module bpwd_queue #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic [1:0]                                       i_push_n,
    input  bpwd_pkg::t_job_ctl                               i_ctl_a,
    input  bpwd_pkg::t_job_ctl                               i_ctl_b,
    input  logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] i_val_a,
    input  logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] i_val_b,
    input  logic [COUNT_BITS-1:0]                            i_cnt_a,
    input  logic [COUNT_BITS-1:0]                            i_cnt_b,
    output logic [1:0]                                       o_free,
    input  logic                                             i_pop,
    output logic                                             o_empty,
    output bpwd_pkg::t_job_ctl                               o_ctl,
    output logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] o_val,
    output logic [COUNT_BITS-1:0]                            o_cnt
);
    import bpwd_pkg::*;

    t_job_ctl                     r_ctl [2];
    logic [NBANDS-1:0][SUM_W-1:0] r_val [2];
    logic [COUNT_BITS-1:0]        r_cnt [2];
    logic                         r_head;
    logic [1:0]                   r_n;
    logic                         w0;

    assign o_free  = 2'd2 - r_n;
    assign o_empty = (r_n == 2'd0);
    assign o_ctl   = r_ctl[r_head];
    assign o_val   = r_val[r_head];
    assign o_cnt   = r_cnt[r_head];
    assign w0      = r_head ^ r_n[0];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_ctl[w0] <= i_ctl_a;
            r_val[w0] <= i_val_a;
            r_cnt[w0] <= i_cnt_a;
        end
        if (i_push_n == 2'd2) begin
            r_ctl[!w0] <= i_ctl_b;
            r_val[!w0] <= i_val_b;
            r_cnt[!w0] <= i_cnt_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_n    <= 2'd0;
        end else begin
            if (i_pop) begin
                r_head <= !r_head;
            end
            r_n <= r_n + i_push_n - {1'b0, i_pop};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 2'd2) else $error("queue fill above two");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n <= o_free) else $error("queue push beyond free room");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");

endmodule

// ===== hw/rtl/bpwd_back.sv =====
// ----------------------------------------------------------------------------
// bpwd_back: level engine
// Turns one job into eight level bytes, one band at a time: optional
// averaging divide, then a linear scale, a clamp to 0 or 255, or the iterative power curve.
// ----------------------------------------------------------------------------
module bpwd_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_empty,
    output logic                                             o_pop,
    input  bpwd_pkg::t_job_ctl                               i_ctl,
    input  logic [bpwd_pkg::NBANDS-1:0][bpwd_pkg::SUM_W-1:0] i_val,
    input  logic [COUNT_BITS-1:0]                            i_cnt,
    output logic                                             o_valid,
    input  logic                                             i_stall,
    output logic                                             o_kind,
    output logic                                             o_last,
    output logic [bpwd_pkg::NBANDS-1:0][7:0]                 o_level
);
    import bpwd_pkg::*;

    localparam int EW   = $clog2(SAMPLE_BITS);
    localparam int LV_W = EW + 16;
    localparam logic [SUM_W-1:0] FULL = SUM_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [LV_W-1:0] LV_TOP = LV_W'(SAMPLE_BITS - 1) << 16;

    t_bk_state                    r_state, n_state;
    logic [2:0]                   r_band;
    t_job_ctl                     r_ctl;
    logic [NBANDS-1:0][SUM_W-1:0] r_val;
    logic [COUNT_BITS-1:0]        r_cnt;
    logic [SUM_W-1:0]             r_p;
    logic [SUM_W:0]               r_dn;
    logic [COUNT_BITS-1:0]        r_rem;
    logic [5:0]                   r_step;
    logic [30:0]                  r_m;
    logic [EW-1:0]                r_e;
    logic [15:0]                  r_lg;
    logic [LV_W-1:0]              r_t;
    logic [30:0]                  r_r;
    logic [3:0]                   r_k;
    logic [7:0]                   r_lev [NBANDS];
    logic                         r_ovalid;

    logic                         is_lin, direct, lev_we, out_load, last_band;
    logic [7:0]                   cls_lev, fin_lev, lev_in;
    logic [39:0]                  lin_prod;
    logic [39:0]                  lin_raw;
    logic [EW-1:0]                e_now;
    logic [61:0]                  m_init;
    logic [61:0]                  sq;
    logic [COUNT_BITS:0]          rem_sh;
    logic                         q_bit;
    logic [LV_W-1:0]              lval;
    logic [LV_W+16:0]             g_prod;
    logic [61:0]                  ex_prod;
    logic [30:0]                  r_shift;
    logic [31:0]                  s_sum;
    logic [25:0]                  lev_prod;
    logic [SUM_W:0]               div_init;

    function automatic logic [SUM_W-1:0] i_val_sel();
        return r_val[r_band];
    endfunction

    function automatic logic [COUNT_BITS-1:0] i_cnt_half();
        return r_cnt >> 1;
    endfunction

    // band datapath
    always_comb begin
        is_lin   = !r_ctl.avg && (r_band >= 3'd2) && (r_band <= 3'd5);
        lin_prod = {8'b0, r_p} * 40'd255 + 40'(FULL >> 1);
        lin_raw  = lin_prod >> (SAMPLE_BITS - 1);
        direct   = is_lin || (r_p == '0) || (r_p >= FULL);
        if (is_lin) begin
            cls_lev = (lin_raw > 40'd255) ? 8'd255 : lin_raw[7:0];
        end else if (r_p == '0) begin
            cls_lev = 8'd0;
        end else begin
            cls_lev = 8'd255;
        end
        e_now = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (r_p[i]) begin
                e_now = EW'(i);
            end
        end
        m_init  = {30'b0, r_p} << (30 - e_now);
        sq      = {31'b0, r_m} * {31'b0, r_m};
        rem_sh  = {r_rem, r_dn[SUM_W]};
        q_bit   = rem_sh >= {1'b0, r_cnt};
        lval    = LV_TOP - {r_e, r_lg};
        g_prod  = {17'b0, lval} * (LV_W+17)'(GAMMA_Q16) + (LV_W+17)'(32768);
        ex_prod = {31'b0, r_r} * {31'b0, PW_COEF[r_k]};
        r_shift = r_r >> r_t[LV_W-1:16];
        s_sum   = {1'b0, r_shift} + 32'd8192;
        lev_prod = {8'b0, s_sum[31:14]} * 26'd255 + 26'd32768;
        fin_lev = (lev_prod[25:16] > 10'd255) ? 8'd255 : lev_prod[23:16];
        div_init = {1'b0, i_val_sel()} + (SUM_W+1)'(i_cnt_half());
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (!i_empty) n_state = BK_BAND;
            BK_BAND:  n_state = r_ctl.avg ? BK_DIV : BK_CLASS;
            BK_DIV:   if (r_step == 6'(DIV_STEPS - 1)) n_state = BK_CLASS;
            BK_CLASS: begin
                if (direct) begin
                    n_state = last_band ? BK_OUT : BK_BAND;
                end else begin
                    n_state = BK_LOG;
                end
            end
            BK_LOG:   if (r_step == 6'(LOG_STEPS - 1)) n_state = BK_GAM;
            BK_GAM:   n_state = BK_EXP;
            BK_EXP:   if (r_k == 4'd0) n_state = BK_FIN;
            BK_FIN:   n_state = last_band ? BK_OUT : BK_BAND;
            BK_OUT:   if (out_load) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        last_band = (r_band == 3'(NBANDS - 1));
        o_pop     = (r_state == BK_IDLE) && !i_empty;
        out_load  = (r_state == BK_OUT) && (!r_ovalid || !i_stall);
        lev_we    = ((r_state == BK_CLASS) && direct) || (r_state == BK_FIN);
        lev_in    = (r_state == BK_FIN) ? fin_lev : cls_lev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
            r_band   <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_band <= '0;
            end else if (lev_we) begin
                r_band <= r_band + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl <= i_ctl;
            r_val <= i_val;
            r_cnt <= i_cnt;
        end
        if (lev_we) begin
            r_lev[r_band] <= lev_in;
        end
        case (r_state)
            BK_BAND: begin
                r_p    <= i_val_sel();
                r_dn   <= div_init;
                r_rem  <= '0;
                r_step <= '0;
            end
            BK_DIV: begin
                r_rem  <= q_bit ? COUNT_BITS'(rem_sh - {1'b0, r_cnt})
                                : COUNT_BITS'(rem_sh);
                r_dn   <= {r_dn[SUM_W-1:0], q_bit};
                r_step <= r_step + 1'b1;
                r_p    <= r_dn[SUM_W-2:0] == '0 ? {r_dn[SUM_W-2:0], q_bit}
                                                : {r_dn[SUM_W-2:0], q_bit};
            end
            BK_CLASS: begin
                r_m    <= m_init[30:0];
                r_e    <= e_now;
                r_lg   <= '0;
                r_step <= '0;
            end
            BK_LOG: begin
                r_m    <= sq[61] ? sq[61:31] : sq[60:30];
                r_lg   <= {r_lg[14:0], sq[61]};
                r_step <= r_step + 1'b1;
            end
            BK_GAM: begin
                r_t <= g_prod[LV_W+15:16];
                r_r <= 31'h4000_0000;
                r_k <= 4'd15;
            end
            BK_EXP: begin
                if (r_t[r_k]) begin
                    r_r <= ex_prod[60:30];
                end
                r_k <= r_k - 1'b1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            o_kind <= r_ctl.kind;
            o_last <= r_ctl.last;
            for (int i = 0; i < NBANDS; i++) begin
                o_level[i] <= r_lev[i];
            end
        end
    end

    assign o_valid = r_ovalid;

    // band index wraps to zero once the last band is written
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BK_BAND) && (r_band == 3'd0))
        else $error("job start did not reset band");
    a_out_after_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_band == 3'd0)) else $error("point sent before all bands");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid) else $error("loaded point not shown");

endmodule
